@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/scd_pkg.sv @@
// ---------------------------------------------------------------------------
// scd_pkg
// Types, constants and helper functions of the cheat code decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

	localparam int BUF_DEPTH = 12;
	localparam int CNT_W     = 4;

	localparam logic [CNT_W-1:0] LEN_AR  = 4'd8;
	localparam logic [CNT_W-1:0] LEN_9   = 4'd9;
	localparam logic [CNT_W-1:0] LEN_CMP = 4'd12;
	localparam logic [CNT_W-1:0] LEN_MAX = 4'd12;

	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_QMARK = 8'h3f;

	localparam logic [1:0] FMT_GG            = 2'd0;
	localparam logic [1:0] FMT_AR            = 2'd1;
	localparam logic [1:0] FMT_ADDR_DATA     = 2'd2;
	localparam logic [1:0] FMT_ADDR_CMP_DATA = 2'd3;

	// hex digit value -> position in the game genie letter set "df4709156bc8a23e"
	localparam logic [3:0] GG_DECODE [16] = '{
		4'd4, 4'd6, 4'd13, 4'd14, 4'd2, 4'd7, 4'd8, 4'd3,
		4'd11, 4'd5, 4'd12, 4'd9, 4'd10, 4'd0, 4'd15, 4'd1
	};

	// source bit of the raw 32-bit value for address bits 23 down to 0
	localparam logic [4:0] GG_PERM [24] = '{
		5'd13, 5'd12, 5'd11, 5'd10, 5'd5, 5'd4, 5'd3, 5'd2,
		5'd23, 5'd22, 5'd21, 5'd20, 5'd1, 5'd0, 5'd15, 5'd14,
		5'd19, 5'd18, 5'd17, 5'd16, 5'd9, 5'd8, 5'd7, 5'd6
	};

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} scd_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [1:0]  format;
		logic [23:0] address;
		logic [7:0]  patch_value;
		logic [7:0]  compare_value;
		logic        has_compare;
	} scd_out_t;

	typedef struct packed {
		logic write;
		logic set_overflow;
		logic load_result;
	} scd_cmd_t;

	typedef struct packed {
		logic full;
	} scd_status_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	// value of a lowercase hex digit; meaningless for other characters
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		return (c[6]) ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/scd_ctrl.sv @@
// ---------------------------------------------------------------------------
// scd_ctrl
// Controller: collects characters, triggers the decode cycle, holds the
// result valid until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	input  logic                 last_char,
	output logic                 char_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  scd_pkg::scd_status_t status,
	output scd_pkg::scd_cmd_t    cmd
);
	import scd_pkg::*;

	localparam logic [0:0] ST_COLLECT = 1'b0;
	localparam logic [0:0] ST_DECODE  = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       res_valid_q;
	logic       accept;

	assign char_stall = (state_q == ST_DECODE) || (res_valid_q && res_stall);
	assign accept     = char_valid && !char_stall;
	assign res_valid  = res_valid_q;

	assign cmd.write        = accept && !status.full;
	assign cmd.set_overflow = accept && status.full;
	assign cmd.load_result  = (state_q == ST_DECODE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (accept && last_char) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_COLLECT;
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/scd_datapath.sv @@
// ---------------------------------------------------------------------------
// scd_datapath
// Character buffer, count and overflow flag, format decode and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scd_pkg::scd_cmd_t    cmd,
	input  scd_pkg::scd_in_t     char_item,
	output scd_pkg::scd_status_t status,
	output scd_pkg::scd_out_t    res_item
);
	import scd_pkg::*;

	logic [7:0]       buf_q [BUF_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	scd_out_t         res_q;
	scd_out_t         dec;

	logic [3:0]           hv [BUF_DEPTH];
	logic [BUF_DEPTH-1:0] hok;
	logic [31:0]          gg_r;
	logic [23:0]          gg_addr;
	logic                 gg_ok;
	logic [23:0]          run_addr;
	logic                 addr_ok;

	assign status.full = (count_q == LEN_MAX);
	assign res_item    = res_q;

	always_ff @(posedge clk) begin
		if (cmd.write) buf_q[count_q] <= char_item.character;
		if (cmd.load_result) res_q <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.load_result) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (cmd.write) count_q <= count_q + 1'b1;
			if (cmd.set_overflow) overflow_q <= 1'b1;
		end
	end

	// per-character digit check and value
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			hok[i] = is_hex(buf_q[i]);
			hv[i]  = hex_value(buf_q[i]);
		end
	end

	// game genie: letter substitution, then address bit permutation
	always_comb begin
		gg_r = {GG_DECODE[hv[0]], GG_DECODE[hv[1]], GG_DECODE[hv[2]], GG_DECODE[hv[3]],
			GG_DECODE[hv[5]], GG_DECODE[hv[6]], GG_DECODE[hv[7]], GG_DECODE[hv[8]]};
		for (int i = 0; i < 24; i++) begin
			gg_addr[23-i] = gg_r[GG_PERM[i]];
		end
	end

	assign gg_ok    = &{hok[8:5], hok[3:0]};
	assign run_addr = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5]};
	assign addr_ok  = &hok[5:0];

	always_comb begin
		dec = '0;
		priority if (overflow_q) begin
			dec = '0;
		end else if (count_q == LEN_9 && buf_q[4] == CH_DASH) begin
			if (gg_ok) begin
				dec.valid_res   = 1'b1;
				dec.format      = FMT_GG;
				dec.address     = gg_addr;
				dec.patch_value = gg_r[31:24];
			end
		end else if (count_q == LEN_AR) begin
			if (&hok[7:0]) begin
				dec.valid_res   = 1'b1;
				dec.format      = FMT_AR;
				dec.address     = run_addr;
				dec.patch_value = {hv[6], hv[7]};
			end
		end else if (count_q == LEN_9 && buf_q[6] == CH_EQ) begin
			if (addr_ok && hok[7] && hok[8]) begin
				dec.valid_res   = 1'b1;
				dec.format      = FMT_ADDR_DATA;
				dec.address     = run_addr;
				dec.patch_value = {hv[7], hv[8]};
			end
		end else if (count_q == LEN_CMP && buf_q[6] == CH_EQ && buf_q[9] == CH_QMARK) begin
			if (addr_ok && hok[7] && hok[8] && hok[10] && hok[11]) begin
				dec.valid_res     = 1'b1;
				dec.format        = FMT_ADDR_CMP_DATA;
				dec.address       = run_addr;
				dec.compare_value = {hv[7], hv[8]};
				dec.patch_value   = {hv[10], hv[11]};
				dec.has_compare   = 1'b1;
			end
		end else begin
			dec = '0;
		end
	end

endmodule

`default_nettype wire

@@ sv/snes_cheat_code_decoder.sv @@
// ---------------------------------------------------------------------------
// snes_cheat_code_decoder
// Decodes a cheat code streamed one ASCII character per item.
// Input channel (char_valid/char_stall/char_item): one character per item,
// last_char set on the final one. Up to 12 characters are buffered; extra
// characters are dropped and make the code invalid.
// Output channel (res_valid/res_stall/res_item): one result per code, with
// format, address, patch and compare bytes; all fields zero when invalid.
// Throughput: one character per cycle. After the last character the input
// stalls for the decode state (the format decode from the character buffer
// is registered). Taking the last character moves the controller to its
// decode state, which loads the result register and sets res_valid.
// While a result waits under res_stall the input stalls too; characters
// are taken again in the cycle the result is consumed.
// Reset (arst_n low): buffer count and overflow cleared, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module snes_cheat_code_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  scd_pkg::scd_in_t  char_item,
	output logic              res_valid,
	input  logic              res_stall,
	output scd_pkg::scd_out_t res_item
);
	import scd_pkg::*;

	scd_cmd_t    cmd;
	scd_status_t status;
	logic        last_taken;
	logic        res_fields_zero;

	// controller: accept/stall, decode trigger, result valid
	scd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.last_char  (char_item.last_char),
		.char_stall (char_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: buffer, count, overflow, decode, result register
	scd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_item (char_item),
		.status    (status),
		.res_item  (res_item)
	);

	assign last_taken      = char_valid && !char_stall && char_item.last_char;
	assign res_fields_zero = res_item.format == FMT_GG && res_item.address == 24'd0
		&& res_item.patch_value == 8'd0 && res_item.compare_value == 8'd0
		&& !res_item.has_compare;

	// last character always leads to the single decode cycle
	`SCD_ASSERT_NEXT(a_last_to_decode, clk, arst_n, last_taken, char_stall && !res_valid)
	// the decode cycle always produces a result
	`SCD_ASSERT_NEXT(a_decode_to_result, clk, arst_n, char_stall && !res_valid, res_valid)
	// invalid codes carry all-zero fields
	`SCD_ASSERT_IMPL(a_invalid_zero, clk, arst_n, res_valid && !res_item.valid_res, res_fields_zero)
	// compare byte only for a valid address=compare?data code
	`SCD_ASSERT_IMPL(a_compare_fmt, clk, arst_n, res_valid && res_item.has_compare, res_item.valid_res && res_item.format == FMT_ADDR_CMP_DATA)

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cheat code decoder. Codes are streamed one
// character per item and every result is checked field by field against
// the known result of a typed directed row or a local model of the decode.
// A directed table comes first, then random codes over three idling phases,
// with one long output hold-off to back up the input.
`default_nettype none

module tb_top;
	import scd_pkg::*;

	localparam int CODE_MAX    = 12;     // characters held per code
	localparam int RAND_CHARS  = 1140;   // random characters, split over three phases
	localparam int HOLD_LEN    = 300;    // long receiver hold-off, in cycles
	localparam int DRAIN_WAIT  = 8;      // extra wait once every expected result is checked
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_N       = 22;

	localparam scd_out_t NO_CODE = '0;

	// game genie letter for each 4-bit value
	localparam logic [7:0] GENIE_SET [16] = '{
		"d", "f", "4", "7", "0", "9", "1", "5",
		"6", "b", "c", "8", "a", "2", "3", "e"
	};

	// raw bit feeding address bits 23 down to 0
	localparam int GENIE_SRC [24] = '{
		13, 12, 11, 10, 5, 4, 3, 2, 23, 22, 21, 20,
		1, 0, 15, 14, 19, 18, 17, 16, 9, 8, 7, 6
	};

	localparam logic [7:0] SEPARATORS [3] = '{"-", "=", "?"};

	// Directed codes. A typed row carries its known result; the others go
	// through the local decode model.
	localparam string DIR_CODE [DIR_N] = '{
		"ffffffff",           // action replay, all ones
		"00000000",           // action replay, all zeros
		"eeee-eeee",          // genie, every raw bit set
		"dddd-dddd",          // genie, every raw bit clear
		"ffffff=ff?ff",       // compare form, all ones
		"000000=00",          // address=data, all zeros
		"c264-6d17",
		"0123-4567",
		"7e0012=a5",
		"7e0012=5a?a5",
		"1f2e3d4c",
		"ABCDEF12",           // uppercase hex is not a digit
		"7e0012=5a?a5b",      // one character too many
		"0123456789abcdef",   // well past the buffer
		"89ab-c=de",          // both separators: genie wins and fails
		"x",                  // single character
		"7e0012-5a",          // nine characters, no known shape
		"7e0012=5a!a5",       // twelve characters, wrong second separator
		"7e001g12",           // non-hex in action replay
		"7e0012=5G?a5",       // uppercase in compare form
		"0123456789ab",       // twelve digits, no separators
		"DDDD-dddd"           // uppercase genie letters
	};

	localparam bit DIR_TYPED [DIR_N] = '{
		1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0,
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
	};

	localparam scd_out_t DIR_WANT [DIR_N] = '{
		{1'b1, FMT_AR, 24'hffffff, 8'hff, 8'h00, 1'b0},
		{1'b1, FMT_AR, 24'h000000, 8'h00, 8'h00, 1'b0},
		{1'b1, FMT_GG, 24'hffffff, 8'hff, 8'h00, 1'b0},
		{1'b1, FMT_GG, 24'h000000, 8'h00, 8'h00, 1'b0},
		{1'b1, FMT_ADDR_CMP_DATA, 24'hffffff, 8'hff, 8'hff, 1'b1},
		{1'b1, FMT_ADDR_DATA, 24'h000000, 8'h00, 8'h00, 1'b0},
		NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE,
		NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE,
		NO_CODE, NO_CODE, NO_CODE, NO_CODE, NO_CODE
	};

	logic     clk;
	logic     arst_n;
	logic     char_valid;
	logic     char_stall;
	scd_in_t  char_item;
	logic     res_valid;
	logic     res_stall;
	scd_out_t res_item;

	// model state of the character buffer
	logic [7:0] code_buf [CODE_MAX];
	int         code_len = 0;
	bit         code_ovf = 0;

	scd_out_t   expected_codes [$];   // decoded results still owed by the block
	logic [7:0] code_chars [$];       // code being sent
	scd_out_t   head_code;

	int errors = 0;
	int chars_sent = 0;
	int cycles = 0;
	int phase = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	snes_cheat_code_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item (char_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Decode model
	// ---------------------------------------------------------------------

	// lowercase hex digit; bit 4 set when c is not one
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, c[3:0]};
		if (c >= 8'h61 && c <= 8'h66)
			return {1'b0, 4'(c - 8'h57)};
		return 5'h10;
	endfunction

	function automatic logic [4:0] genie_digit(input logic [7:0] c);
		for (int i = 0; i < 16; i++)
			if (GENIE_SET[i] == c)
				return {1'b0, 4'(i)};
		return 5'h10;
	endfunction

	// n hex digits from pos, most significant first
	function automatic bit hex_field(input int pos, input int n, output logic [23:0] val);
		logic [4:0] d;
		val = '0;
		for (int i = 0; i < n; i++) begin
			d = hex_digit(code_buf[pos + i]);
			if (d[4])
				return 1'b0;
			val = {val[19:0], d[3:0]};
		end
		return 1'b1;
	endfunction

	function automatic scd_out_t decode_cheat();
		scd_out_t    r;
		logic [31:0] raw;
		logic [23:0] addr, data, cmp;
		logic [4:0]  g;
		bit          ok;
		r = '0;
		raw = '0;
		addr = '0;
		data = '0;
		cmp = '0;
		ok = 1'b0;
		if (code_ovf) begin
			ok = 1'b0;
		end else if (code_len == 9 && code_buf[4] == "-") begin
			// genie: eight letters to 32 raw bits, then scatter the address
			ok = 1'b1;
			for (int i = 0; i < 9; i++) begin
				if (i != 4) begin
					g = genie_digit(code_buf[i]);
					if (g[4])
						ok = 1'b0;
					raw = {raw[27:0], g[3:0]};
				end
			end
			for (int i = 0; i < 24; i++)
				addr[23 - i] = raw[GENIE_SRC[i]];
			data = {16'h0, raw[31:24]};
			r.format = FMT_GG;
		end else if (code_len == 8) begin
			ok = hex_field(0, 6, addr) && hex_field(6, 2, data);
			r.format = FMT_AR;
		end else if (code_len == 9 && code_buf[6] == "=") begin
			ok = hex_field(0, 6, addr) && hex_field(7, 2, data);
			r.format = FMT_ADDR_DATA;
		end else if (code_len == 12 && code_buf[6] == "=" && code_buf[9] == "?") begin
			ok = hex_field(0, 6, addr) && hex_field(7, 2, cmp) && hex_field(10, 2, data);
			r.format = FMT_ADDR_CMP_DATA;
			r.compare_value = cmp[7:0];
			r.has_compare = 1'b1;
		end
		if (!ok)
			return NO_CODE;
		r.valid_res = 1'b1;
		r.address = addr;
		r.patch_value = data[7:0];
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Code generation
	// ---------------------------------------------------------------------

	// 0..9 -> '0'..'9', 10..15 -> 'a'..'f'
	function automatic logic [7:0] hex_char(input int v);
		return (v < 10) ? 8'(48 + v) : 8'(87 + v);
	endfunction

	task automatic build_form(input logic [1:0] fmt);
		int n;
		n = (fmt == FMT_AR) ? 8 : (fmt == FMT_ADDR_CMP_DATA) ? 12 : 9;
		for (int i = 0; i < n; i++)
			code_chars.push_back(hex_char($urandom_range(15)));
		if (fmt == FMT_GG)
			code_chars[4] = "-";
		if (fmt == FMT_ADDR_DATA || fmt == FMT_ADDR_CMP_DATA)
			code_chars[6] = "=";
		if (fmt == FMT_ADDR_CMP_DATA)
			code_chars[9] = "?";
	endtask

	// Mostly well-formed codes with random digits; a share is broken
	// (one char hit, uppercase, or lengthened) and the rest is noise.
	task automatic build_code();
		int kind;
		int n;
		logic [1:0] fmt;
		kind = $urandom_range(99);
		code_chars.delete();
		if (kind < 90) begin
			fmt = (kind < 20) ? FMT_GG : (kind < 40) ? FMT_AR :
				(kind < 58) ? FMT_ADDR_DATA : (kind < 76) ? FMT_ADDR_CMP_DATA :
				2'($urandom_range(3));
			build_form(fmt);
			if (kind >= 76) begin
				case ($urandom_range(2))
					0: code_chars[$urandom_range(code_chars.size() - 1)] = 8'($urandom_range(255));
					1: code_chars[$urandom_range(code_chars.size() - 1)] = 8'(65 + $urandom_range(5));
					default: begin
						repeat ($urandom_range(4, 1))
							code_chars.push_back(hex_char($urandom_range(15)));
					end
				endcase
			end
		end else begin
			n = $urandom_range(16, 1);
			repeat (n) begin
				case ($urandom_range(3))
					0: code_chars.push_back(hex_char($urandom_range(15)));
					1: code_chars.push_back(SEPARATORS[$urandom_range(2)]);
					default: code_chars.push_back(8'($urandom_range(255)));
				endcase
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Sender: one char per item, last_char on the final one. The model is
	// updated at the edge where the item is taken.
	// ---------------------------------------------------------------------
	task automatic send_code(input bit typed, input scd_out_t want);
		scd_in_t    it;
		logic [7:0] c;
		logic       last;
		for (int i = 0; i < code_chars.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				char_valid <= 1'b0;
				@(posedge clk);
			end
			c = code_chars[i];
			last = (i == code_chars.size() - 1);
			it.character = c;
			it.last_char = last;
			char_valid <= 1'b1;
			char_item <= it;
			// outputs read right after the edge hold their pre-edge values
			do
				@(posedge clk);
			while (char_stall);
			chars_sent++;
			if (code_len < CODE_MAX) begin
				code_buf[code_len] = c;
				code_len++;
			end else begin
				code_ovf = 1'b1;
			end
			if (last) begin
				expected_codes.push_back(typed ? want : decode_cheat());
				code_len = 0;
				code_ovf = 1'b0;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stall, plus one long hold-off when the no-idle phase
	// starts, so the pending result backs up into the input.
	// ---------------------------------------------------------------------
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result check, oldest expectation first
	// ---------------------------------------------------------------------
	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res_item);
				errors++;
			end else begin
				head_code = expected_codes.pop_front();
				check_field("valid_res", 24'(head_code.valid_res), 24'(res_item.valid_res));
				check_field("format", 24'(head_code.format), 24'(res_item.format));
				check_field("address", head_code.address, res_item.address);
				check_field("patch_value", 24'(head_code.patch_value),
					24'(res_item.patch_value));
				check_field("compare_value", 24'(head_code.compare_value),
					24'(res_item.compare_value));
				check_field("has_compare", 24'(head_code.has_compare),
					24'(res_item.has_compare));
			end
		end
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		string s;
		int    target;
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_item <= '0;
		send_idle_pct = 30;
		recv_idle_pct = 63;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_N; r++) begin
			s = DIR_CODE[r];
			code_chars.delete();
			for (int i = 0; i < s.len(); i++)
				code_chars.push_back(s[i]);
			send_code(DIR_TYPED[r], DIR_WANT[r]);
		end

		// random codes: sender-light, then receiver-light, then full rate
		for (int p = 0; p < 3; p++) begin
			phase = p;
			send_idle_pct = (p == 0) ? 30 : (p == 1) ? 63 : 0;
			recv_idle_pct = (p == 0) ? 63 : (p == 1) ? 30 : 0;
			target = chars_sent + RAND_CHARS / 3;
			while (chars_sent < target) begin
				build_code();
				send_code(1'b0, NO_CODE);
			end
		end
		char_valid <= 1'b0;

		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/scd_pkg.sv
sv/scd_ctrl.sv
sv/scd_datapath.sv
sv/snes_cheat_code_decoder.sv
bench/tb_top.sv
